FILE: rtl/ramped_gain_mixer_core_assert.svh
// Assertion macros used by the module that checks its own behavior.
// Each macro expects a clock named clk and an active-high reset named rst.
`ifndef RAMPED_GAIN_MIXER_CORE_ASSERT_SVH
`define RAMPED_GAIN_MIXER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RGM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RGM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: rtl/rgm_pkg.sv
`timescale 1ns / 1ps
package rgm_pkg;

  localparam int BLOCK_LEN = 64;
  localparam int RAMP_LEN  = 256;

  localparam int SAMPLE_W  = 24;
  localparam int GAIN_W    = 16;
  localparam int USED_W    = 17;
  localparam int FRAC_BITS = 14;

  localparam logic [GAIN_W-1:0] UNITY_GAIN = GAIN_W'(1 << FRAC_BITS);

  localparam int SIB_W    = $clog2(BLOCK_LEN);
  localparam int POS_W    = $clog2(RAMP_LEN);
  localparam int NEXT_W   = $clog2(RAMP_LEN + 2 * BLOCK_LEN);
  localparam int IDX_W    = $clog2(RAMP_LEN + BLOCK_LEN);
  localparam int BLOCK_SH = $clog2(BLOCK_LEN);
  localparam int RAMP_SH  = $clog2(RAMP_LEN);

  // Gain difference, ramp product, shifted ramp term, gain, effective gain, sample product, scaled sample, sum.
  localparam int DIFF_W  = GAIN_W + 1;
  localparam int RPROD_W = DIFF_W + IDX_W + 1;
  localparam int SH_W    = RPROD_W - BLOCK_SH;
  localparam int G_W     = SH_W + 1;
  localparam int EFF_W   = G_W + 1;
  localparam int SPROD_W = SAMPLE_W + EFF_W;
  localparam int SCL_W   = SPROD_W - FRAC_BITS;
  localparam int SUM_W   = SCL_W + 1;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIX_MODE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_BLOCK = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    MODE_SCALE,
    MODE_ADD,
    MODE_ADD_INV,
    MODE_STEREO
  } mix_mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GAIN,
    ST_MUL,
    ST_FIN
  } rgm_state_t;

  typedef struct packed {
    logic accept;
    logic gain;
    logic mul;
    logic fin;
  } rgm_cmd_t;

  typedef struct packed {
    logic out_stall;
  } rgm_status_t;

  function automatic logic signed [SAMPLE_W-1:0] sat_sample(
    input logic signed [SUM_W-1:0] v
  );
    logic signed [SUM_W-1:0] max_v;
    logic signed [SUM_W-1:0] min_v;
    max_v = SUM_W'((64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1);
    min_v = SUM_W'(-(64'sd1 <<< (SAMPLE_W - 1)));
    if (v > max_v) begin
      return max_v[SAMPLE_W-1:0];
    end else if (v < min_v) begin
      return min_v[SAMPLE_W-1:0];
    end
    return v[SAMPLE_W-1:0];
  endfunction

endpackage

FILE: rtl/rgm_in_if.sv
`timescale 1ns / 1ps
interface rgm_in_if;
  import rgm_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic signed [SAMPLE_W-1:0] accum_left;
  logic signed [SAMPLE_W-1:0] accum_right;
  logic        [GAIN_W-1:0]   requested_gain;

  modport source (output valid, sample, accum_left, accum_right, requested_gain,
                  input ready);
  modport sink (input valid, sample, accum_left, accum_right, requested_gain,
                output ready);
endinterface

FILE: rtl/rgm_out_if.sv
`timescale 1ns / 1ps
interface rgm_out_if;
  import rgm_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] out_left;
  logic signed [SAMPLE_W-1:0] out_right;
  logic signed [USED_W-1:0]   gain_used;
  logic                       ramping;

  modport source (output valid, out_left, out_right, gain_used, ramping,
                  input ready);
  modport sink (input valid, out_left, out_right, gain_used, ramping,
                output ready);
endinterface

FILE: rtl/rgm_ctrl.sv
`timescale 1ns / 1ps
module rgm_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rgm_pkg::rgm_status_t status,
  output rgm_pkg::rgm_cmd_t    cmd
);
  import rgm_pkg::*;

  rgm_state_t state;
  rgm_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_GAIN;
      end
      ST_GAIN: state_next = ST_MUL;
      ST_MUL:  state_next = ST_FIN;
      ST_FIN: begin
        if (!status.out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // The input side stays closed while reset is held, so nothing is taken in
  // that the datapath would then drop.
  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        in_ready   = !rst;
        cmd.accept = in_valid && !rst;
      end
      ST_GAIN: cmd.gain = 1'b1;
      ST_MUL:  cmd.mul = 1'b1;
      ST_FIN:  cmd.fin = !status.out_stall;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

FILE: rtl/rgm_datapath.sv
`timescale 1ns / 1ps
module rgm_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  rgm_pkg::rgm_cmd_t                   cmd,
  output rgm_pkg::rgm_status_t                status,
  input  logic                                cfg_we,
  input  logic [rgm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rgm_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic signed [rgm_pkg::SAMPLE_W-1:0] sample,
  input  logic signed [rgm_pkg::SAMPLE_W-1:0] accum_left,
  input  logic signed [rgm_pkg::SAMPLE_W-1:0] accum_right,
  input  logic [rgm_pkg::GAIN_W-1:0]          requested_gain,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [rgm_pkg::SAMPLE_W-1:0] out_left,
  output logic signed [rgm_pkg::SAMPLE_W-1:0] out_right,
  output logic signed [rgm_pkg::USED_W-1:0]   gain_used,
  output logic                                ramping
);
  import rgm_pkg::*;

  // Configuration.
  mix_mode_t mix_mode;
  logic      one_block_ramp;

  // Ramp state.
  logic [GAIN_W-1:0] settled_gain;
  logic [GAIN_W-1:0] ramp_target;
  logic [GAIN_W-1:0] ramp_start;
  logic [POS_W-1:0]  ramp_base;
  logic [POS_W-1:0]  ramp_position;
  logic [SIB_W-1:0]  sample_in_block;
  logic              smoothing_active;

  // Per-item registers.
  logic signed [SAMPLE_W-1:0] smp_r;
  logic signed [SAMPLE_W-1:0] accl_r;
  logic signed [SAMPLE_W-1:0] accr_r;
  logic signed [RPROD_W-1:0]  rprod;
  logic signed [SPROD_W-1:0]  sprod;
  logic signed [EFF_W-1:0]    eff_r;
  logic                       flat_zero_r;

  // Block-start decision.
  logic              block_start;
  logic              hold_flat;
  logic [POS_W-1:0]  base_sel;
  logic [NEXT_W-1:0] next_pos;
  logic [NEXT_W-1:0] ramp_len_sel;
  logic              ramp_ends;

  always_comb begin
    block_start  = (sample_in_block == '0);
    hold_flat    = (settled_gain == requested_gain) && (ramp_position == '0);
    base_sel     = one_block_ramp ? '0 : ramp_position;
    next_pos     = NEXT_W'(base_sel) + NEXT_W'(BLOCK_LEN);
    ramp_len_sel = one_block_ramp ? NEXT_W'(BLOCK_LEN) : NEXT_W'(RAMP_LEN);
    ramp_ends    = (next_pos >= ramp_len_sel);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mix_mode         <= MODE_SCALE;
      one_block_ramp   <= 1'b0;
      settled_gain     <= UNITY_GAIN;
      ramp_target      <= UNITY_GAIN;
      ramp_start       <= UNITY_GAIN;
      ramp_base        <= '0;
      ramp_position    <= '0;
      sample_in_block  <= '0;
      smoothing_active <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MIX_MODE:  mix_mode <= mix_mode_t'(cfg_data);
          CFG_ONE_BLOCK: one_block_ramp <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.accept && block_start) begin
        if (hold_flat) begin
          smoothing_active <= 1'b0;
        end else begin
          smoothing_active <= 1'b1;
          if (ramp_position == '0) begin
            ramp_target <= requested_gain;
            ramp_start  <= settled_gain;
          end
          ramp_base <= base_sel;
          if (ramp_ends) begin
            settled_gain  <= (ramp_position == '0) ? requested_gain : ramp_target;
            ramp_position <= '0;
          end else begin
            ramp_position <= next_pos[POS_W-1:0];
          end
        end
      end
      if (cmd.fin) begin
        if (sample_in_block == SIB_W'(BLOCK_LEN - 1)) begin
          sample_in_block <= '0;
        end else begin
          sample_in_block <= sample_in_block + SIB_W'(1);
        end
      end
    end
  end

  // Ramp multiply: (target - start) times the ramp index.
  logic signed [DIFF_W-1:0] diff;
  logic        [IDX_W-1:0]  ramp_idx;

  always_comb begin
    diff     = $signed({1'b0, ramp_target}) - $signed({1'b0, ramp_start});
    ramp_idx = IDX_W'(ramp_base) + IDX_W'(sample_in_block);
  end

  // Gain and sample multiply.
  logic signed [RPROD_W-1:0] rshift;
  logic signed [G_W-1:0]     gain_cur;
  logic signed [EFF_W-1:0]   eff;
  logic                      flat_zero;

  always_comb begin
    rshift   = one_block_ramp ? (rprod >>> BLOCK_SH) : (rprod >>> RAMP_SH);
    if (smoothing_active) begin
      gain_cur = $signed(G_W'({1'b0, ramp_start})) + G_W'($signed(rshift[SH_W-1:0]));
    end else begin
      gain_cur = $signed(G_W'({1'b0, settled_gain}));
    end
    if (mix_mode == MODE_ADD_INV) begin
      eff = $signed(EFF_W'({1'b0, UNITY_GAIN})) - EFF_W'(gain_cur);
    end else begin
      eff = EFF_W'(gain_cur);
    end
    flat_zero = !smoothing_active && (mix_mode != MODE_SCALE) && (eff <= 0);
  end

  // Final scaling, accumulate and saturate.
  logic signed [SPROD_W-1:0] sshift;
  logic signed [SCL_W-1:0]   scl;
  logic signed [SCL_W-1:0]   addend;
  logic signed [SUM_W-1:0]   sum_l;
  logic signed [SUM_W-1:0]   sum_r;

  always_comb begin
    sshift = sprod >>> FRAC_BITS;
    scl    = sshift[SCL_W-1:0];
    addend = flat_zero_r ? '0 : scl;
    if (mix_mode == MODE_SCALE) begin
      sum_l = SUM_W'(scl);
    end else begin
      sum_l = SUM_W'(accl_r) + SUM_W'(addend);
    end
    if (mix_mode == MODE_STEREO) begin
      sum_r = SUM_W'(accr_r) + SUM_W'(addend);
    end else begin
      sum_r = SUM_W'(accr_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      smp_r  <= sample;
      accl_r <= accum_left;
      accr_r <= accum_right;
    end
    if (cmd.gain) begin
      rprod <= diff * $signed({1'b0, ramp_idx});
    end
    if (cmd.mul) begin
      sprod       <= smp_r * eff;
      eff_r       <= eff;
      flat_zero_r <= flat_zero;
    end
    if (cmd.fin) begin
      out_left  <= sat_sample(sum_l);
      out_right <= sat_sample(sum_r);
      gain_used <= flat_zero_r ? '0 : eff_r[USED_W-1:0];
      ramping   <= smoothing_active;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.fin) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign status.out_stall = out_valid && !out_ready;

endmodule

FILE: rtl/ramped_gain_mixer_core.sv
`timescale 1ns / 1ps
// Ramped gain mixer. Each input transaction carries one signed 24-bit sample,
// two accumulator samples and a requested Q2.14 gain; each produces exactly
// one output transaction. Transactions are grouped in blocks of BLOCK_LEN;
// the requested gain is only looked at on the first sample of a block, where
// the block either stays flat at the settled gain or starts or continues a
// linear ramp toward the target, over one block or over RAMP_LEN samples.
// An item passes through acceptance with the block-start update, the ramp
// multiply, the sample multiply, and the saturating add into the output
// register, in that order. The controller takes one item at a time, so a
// new input transaction is accepted only after the last item is loaded into
// the output register, where a finished result waits while the next input
// transaction is accepted. The user must write configuration (mix mode at
// index 0, one-block ramp at index 1) through cfg_we/cfg_index/cfg_data only
// while no item is in flight; the block itself does not enforce this.
module ramped_gain_mixer_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [rgm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rgm_pkg::CFG_DATA_W-1:0]    cfg_data,
  rgm_in_if.sink                            din,
  rgm_out_if.source                         dout
);
  import rgm_pkg::*;

  rgm_cmd_t    cmd;
  rgm_status_t status;

  // The controller sequences one item through the datapath stages and
  // holds the last stage while the output register is still occupied.
  rgm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (din.valid),
    .in_ready (din.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath owns the configuration, the ramp state and the output
  // register; its item steps follow the controller's commands, configuration writes follow cfg_we.
  rgm_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .sample         (din.sample),
    .accum_left     (din.accum_left),
    .accum_right    (din.accum_right),
    .requested_gain (din.requested_gain),
    .out_valid      (dout.valid),
    .out_ready      (dout.ready),
    .out_left       (dout.out_left),
    .out_right      (dout.out_right),
    .gain_used      (dout.gain_used),
    .ramping        (dout.ramping)
  );

  `include "ramped_gain_mixer_core_assert.svh"

  // Only one item is in flight: after an accept the input side closes.
  `RGM_ASSERT_NEXT(a_one_in_flight, din.valid && din.ready, !din.ready && cmd.gain)
  // The ramp multiply is always followed by the sample multiply.
  `RGM_ASSERT_NEXT(a_gain_then_mul, cmd.gain, cmd.mul)
  // Loading the result register always presents a result.
  `RGM_ASSERT_NEXT(a_fin_presents, cmd.fin, dout.valid)
  // The result register is never overwritten while a result waits.
  `RGM_ASSERT_SAME(a_no_overwrite, cmd.fin, !(dout.valid && !dout.ready))

endmodule
